// ===== rtl/table_lookup_bilinear_interp_macros.svh =====
// Assertion macros used by the top lookup table module.
`ifndef TABLE_LOOKUP_BILINEAR_INTERP_MACROS_SVH
`define TABLE_LOOKUP_BILINEAR_INTERP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TLB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define TLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/tlbi_pkg.sv =====
`timescale 1ns / 1ps
package tlbi_pkg;
   localparam int MAX_X_POINTS_DEF = 16;
   localparam int MAX_Y_POINTS_DEF = 16;
   localparam int VALUE_WIDTH_DEF  = 16;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CFG_WIDTH        = 5;
   localparam int SEG_WIDTH        = 4;
   localparam int CMD_WIDTH        = 2;
   localparam int IDX_WIDTH        = 4;

   typedef enum logic [1:0] {
      CMD_WRITE_X    = 2'd0,
      CMD_WRITE_Y    = 2'd1,
      CMD_WRITE_CELL = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   localparam logic [0:0] CSR_X_POINTS = 1'b0;
   localparam logic [0:0] CSR_Y_POINTS = 1'b1;
endpackage

// ===== rtl/tlbi_divider.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage.
// Quotient = (num << FRAC_BITS) / den, num < den, den > 0.
// A tag travels alongside; enable advances every stage at once.
module tlbi_divider #(
   parameter int NUM_WIDTH = 17,
   parameter int FRAC_BITS = 16,
   parameter int TAG_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [NUM_WIDTH-1:0]   num,
   input  logic [NUM_WIDTH-1:0]   den,
   input  logic [TAG_WIDTH-1:0]   tag_in,
   output logic [FRAC_BITS-1:0]   quot,
   output logic [TAG_WIDTH-1:0]   tag_out
);
   localparam int RW = NUM_WIDTH + 1;

   logic [RW-1:0]        rem_ff  [FRAC_BITS];
   logic [NUM_WIDTH-1:0] den_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff    [FRAC_BITS];
   logic [TAG_WIDTH-1:0] tag_ff  [FRAC_BITS];

   // Each stage shifts the remainder and subtracts the divisor if it fits.
   for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
      logic [RW-1:0]        rem_p;
      logic [NUM_WIDTH-1:0] den_p;
      logic [FRAC_BITS-1:0] q_p;
      logic [TAG_WIDTH-1:0] tag_p;
      logic [RW-1:0]        sh;
      logic [RW-1:0]        df;
      logic                 fits;

      // The first stage takes the inputs, later ones the stage before.
      if (s == 0) begin : g_head
         assign rem_p = {1'b0, num};
         assign den_p = den;
         assign q_p   = '0;
         assign tag_p = tag_in;
      end else begin : g_link
         assign rem_p = rem_ff[s-1];
         assign den_p = den_ff[s-1];
         assign q_p   = q_ff[s-1];
         assign tag_p = tag_ff[s-1];
      end

      always_comb begin
         sh   = {rem_p[RW-2:0], 1'b0};
         df   = sh - {1'b0, den_p};
         fits = (sh >= {1'b0, den_p});
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= fits ? df : sh;
            den_ff[s] <= den_p;
            q_ff[s]   <= {q_p[FRAC_BITS-2:0], fits};
            tag_ff[s] <= tag_p;
         end
      end
   end

   assign quot    = q_ff[FRAC_BITS-1];
   assign tag_out = tag_ff[FRAC_BITS-1];
endmodule

// ===== rtl/tlbi_axis.sv =====
`timescale 1ns / 1ps
// One breakpoint axis: storage, segment search and weight pipeline.
// Stage A registers the match flags, stage B picks the segment, then the
// divider stages form the quotient and a final register forms the weight.
module tlbi_axis #(
   parameter int MAX_POINTS  = 16,
   parameter int VALUE_WIDTH = 16,
   parameter int FRAC_BITS   = 16,
   parameter int SEG_W       = 4
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_index,
   input  logic signed [VALUE_WIDTH-1:0] wr_value,
   input  logic [$clog2(MAX_POINTS):0]   points,
   input  logic signed [VALUE_WIDTH-1:0] coord,
   output logic [SEG_W-1:0]              seg,
   output logic [FRAC_BITS:0]            frac
);
   import tlbi_pkg::*;
   localparam int PW = $clog2(MAX_POINTS) + 1;
   localparam int IW = $clog2(MAX_POINTS);
   localparam int DW = VALUE_WIDTH + 1;
   localparam int TW = SEG_W + 2;

   // Weight modes carried alongside the divider.
   localparam logic [1:0] MODE_ZERO  = 2'd0;
   localparam logic [1:0] MODE_FULL  = 2'd1;
   localparam logic [1:0] MODE_DIV   = 2'd2;
   localparam logic [1:0] MODE_START = 2'd3;

   logic signed [VALUE_WIDTH-1:0] bp_ff [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bp_ff[wr_index] <= wr_value;
      end
   end

   // Stage A: compare the coordinate with every breakpoint.
   logic [MAX_POINTS-1:0]         ge_in, ge_ff;
   logic [PW-1:0]                 n_ff;
   logic signed [VALUE_WIDTH-1:0] q_ff;
   logic                          top_in, top_ff, bot_in, bot_ff;
   logic [IW-1:0]                 last_idx;

   always_comb begin
      last_idx = IW'(points - PW'(1));
      for (int k = 0; k < MAX_POINTS; k++) begin
         ge_in[k] = (coord >= bp_ff[k]);
      end
      top_in = (coord >= bp_ff[last_idx]);
      bot_in = (coord <= bp_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ge_ff  <= ge_in;
         n_ff   <= points;
         q_ff   <= coord;
         top_ff <= top_in;
         bot_ff <= bot_in;
      end
   end

   // Stage B: first k with q >= a[k] and q < a[k+1]; fetch its breakpoints.
   logic [IW-1:0] k_sel;
   logic          found;
   logic [SEG_W-1:0]              seg_in, seg_ff;
   logic [1:0]                    mode_in, mode_ff;
   logic [DW-1:0]                 num_in, den_in, num_ff, den_ff;

   always_comb begin
      k_sel = '0;
      found = 1'b0;
      for (int k = MAX_POINTS - 2; k >= 0; k--) begin
         if ((k + 1) < n_ff && ge_ff[k] && !ge_ff[k+1]) begin
            k_sel = IW'(k);
            found = 1'b1;
         end
      end
      num_in = DW'(bp_ff[k_sel + IW'(1)]) - DW'(q_ff);
      den_in = DW'(bp_ff[k_sel + IW'(1)]) - DW'(bp_ff[k_sel]);
      // A coordinate exactly on the lower breakpoint has zero weight.
      if (top_ff) begin
         seg_in  = SEG_W'(n_ff - PW'(2));
         mode_in = MODE_FULL;
      end else if (bot_ff || !found) begin
         seg_in  = '0;
         mode_in = MODE_ZERO;
      end else begin
         seg_in  = SEG_W'(k_sel);
         mode_in = (num_in == den_in) ? MODE_START : MODE_DIV;
      end
      if (mode_in != MODE_DIV) begin
         num_in = '0;
         den_in = DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         seg_ff  <= seg_in;
         mode_ff <= mode_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   logic [FRAC_BITS-1:0] quot;
   logic [TW-1:0]        tag_out;

   tlbi_divider #(.NUM_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .TAG_WIDTH(TW)) u_div (
      .clock   (clock),
      .enable  (enable),
      .num     (num_ff),
      .den     (den_ff),
      .tag_in  ({mode_ff, seg_ff}),
      .quot    (quot),
      .tag_out (tag_out)
   );

   // Final weight: one minus quotient, or a fixed end value.
   always_ff @(posedge clock) begin
      if (enable) begin
         seg <= tag_out[SEG_W-1:0];
         case (tag_out[TW-1:SEG_W])
            MODE_FULL: frac <= (FRAC_BITS+1)'(1) << FRAC_BITS;
            MODE_DIV:  frac <= ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, quot};
            default:   frac <= '0;
         endcase
      end
   end
endmodule

// ===== rtl/tlbi_blend.sv =====
`timescale 1ns / 1ps
// Cell store and four-corner blend. Stage 1 reads the cells, stage 2
// multiplies along y, stage 3 multiplies along x, stage 4 rounds.
module tlbi_blend #(
   parameter int MAX_X_POINTS = 16,
   parameter int MAX_Y_POINTS = 16,
   parameter int VALUE_WIDTH  = 16,
   parameter int FRAC_BITS    = 16,
   parameter int SEG_W        = 4
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_X_POINTS)-1:0] wr_row,
   input  logic [$clog2(MAX_Y_POINTS)-1:0] wr_col,
   input  logic signed [VALUE_WIDTH-1:0] wr_value,
   input  logic [SEG_W-1:0]              xs,
   input  logic [SEG_W-1:0]              ys,
   input  logic [FRAC_BITS:0]            wx,
   input  logic [FRAC_BITS:0]            wy,
   output logic signed [VALUE_WIDTH-1:0] result
);
   import tlbi_pkg::*;
   localparam int XW = $clog2(MAX_X_POINTS);
   localparam int YW = $clog2(MAX_Y_POINTS);
   localparam int FW = FRAC_BITS + 1;
   localparam int TW = VALUE_WIDTH + FW + 1;
   localparam int SW = TW + FW + 1;

   logic signed [VALUE_WIDTH-1:0] mem0 [MAX_X_POINTS*MAX_Y_POINTS];
   logic signed [VALUE_WIDTH-1:0] mem1 [MAX_X_POINTS*MAX_Y_POINTS];
   logic signed [VALUE_WIDTH-1:0] c00_ff, c01_ff, c10_ff, c11_ff;
   logic [XW-1:0] r0, r1;
   logic [YW-1:0] k0, k1;

   always_comb begin
      r0 = XW'(xs);
      r1 = r0 + XW'(1);
      k0 = YW'(ys);
      k1 = k0 + YW'(1);
   end

   // Four copies, one per corner; each is read at one address per cycle
   // through a registered read, held while enable is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem0[{wr_row, wr_col}] <= wr_value;
         mem1[{wr_row, wr_col}] <= wr_value;
      end
   end

   logic signed [VALUE_WIDTH-1:0] mem2 [MAX_X_POINTS*MAX_Y_POINTS];
   logic signed [VALUE_WIDTH-1:0] mem3 [MAX_X_POINTS*MAX_Y_POINTS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem2[{wr_row, wr_col}] <= wr_value;
         mem3[{wr_row, wr_col}] <= wr_value;
      end
   end

   logic [FW-1:0] wx1_ff, wy1_ff, wx2_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         c00_ff <= mem0[{r0, k0}];
         c01_ff <= mem1[{r0, k1}];
         c10_ff <= mem2[{r1, k0}];
         c11_ff <= mem3[{r1, k1}];
         wx1_ff <= wx;
         wy1_ff <= wy;
      end
   end

   // Blend along y for both rows.
   logic signed [TW-1:0] t0_ff, t1_ff;
   logic signed [FW:0]   wyc, wys;
   always_comb begin
      wys = $signed({1'b0, wy1_ff});
      wyc = $signed({1'b0, (FW'(1) << FRAC_BITS) - wy1_ff});
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         t0_ff  <= TW'(c00_ff * wyc) + TW'(c01_ff * wys);
         t1_ff  <= TW'(c10_ff * wyc) + TW'(c11_ff * wys);
         wx2_ff <= wx1_ff;
      end
   end

   // Blend along x, exact in a wide word.
   logic signed [SW-1:0] s_ff;
   logic signed [FW:0]   wxc, wxs;
   always_comb begin
      wxs = $signed({1'b0, wx2_ff});
      wxc = $signed({1'b0, (FW'(1) << FRAC_BITS) - wx2_ff});
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         s_ff <= SW'(t0_ff * wxc) + SW'(t1_ff * wxs);
      end
   end

   // Round half up and drop the fraction bits.
   logic signed [SW-1:0] rnd;
   always_comb begin
      rnd = s_ff + (SW'(1) <<< (2*FRAC_BITS - 1));
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         result <= VALUE_WIDTH'(rnd >>> (2*FRAC_BITS));
      end
   end
endmodule

// ===== rtl/table_lookup_bilinear_interp.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; the per-bit
// divider pipeline sets the depth. A stalled output freezes the whole pipeline;
// breakpoint writes land at acceptance, cell writes after a delay line as deep as
// the axis pipeline, where queries read the cells.
// Reset: synchronous, active high; clears valid bits and sets both point counts
// to 16. Breakpoints and cells are undefined until written.
`include "table_lookup_bilinear_interp_macros.svh"
module table_lookup_bilinear_interp
   import tlbi_pkg::*;
#(
   parameter int MAX_X_POINTS = tlbi_pkg::MAX_X_POINTS_DEF,
   parameter int MAX_Y_POINTS = tlbi_pkg::MAX_Y_POINTS_DEF,
   parameter int VALUE_WIDTH  = tlbi_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS    = tlbi_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [tlbi_pkg::CFG_WIDTH-1:0] csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd, row_index, col_index, write_value, x_in, y_in (from bit 0)
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result, x_segment, y_segment, x_fraction, y_fraction (from bit 0)
   output logic [63:0]  rsp_tdata
);
   localparam int LAT = FRAC_BITS + 7;
   localparam int PW  = CFG_WIDTH;
   localparam int WD  = FRAC_BITS + 3;

   logic [PW-1:0] xp_ff, yp_ff, xn, yn;

   always_ff @(posedge clock) begin
      if (reset) begin
         xp_ff <= PW'(16);
         yp_ff <= PW'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_POINTS: xp_ff <= csr_wdata;
            default:      yp_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      xn = (xp_ff < PW'(2)) ? PW'(2) : (xp_ff > PW'(MAX_X_POINTS)) ? PW'(MAX_X_POINTS) : xp_ff;
      yn = (yp_ff < PW'(2)) ? PW'(2) : (yp_ff > PW'(MAX_Y_POINTS)) ? PW'(MAX_Y_POINTS) : yp_ff;
   end

   // Input fields.
   cmd_type cmd;
   logic [3:0] row, col;
   logic signed [15:0] wv, xq, yq;
   assign cmd = cmd_type'(req_tdata[1:0]);
   assign row = req_tdata[5:2];
   assign col = req_tdata[9:6];
   assign wv  = req_tdata[25:10];
   assign xq  = req_tdata[41:26];
   assign yq  = req_tdata[57:42];

   logic enable, acc;
   logic [LAT-1:0] vld_ff;
   assign enable     = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = enable;
   assign acc        = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[LAT-2:0], acc && (cmd == CMD_QUERY)};
      end
   end

   // Cell writes travel as deep as the axis pipeline, so every query reads
   // the cells as they stood when it was accepted.
   logic [WD-1:0]      cw_vld_ff;
   logic [3:0]         cw_row_ff [WD];
   logic [3:0]         cw_col_ff [WD];
   logic signed [15:0] cw_val_ff [WD];

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_vld_ff <= '0;
      end else if (enable) begin
         cw_vld_ff <= {cw_vld_ff[WD-2:0], acc && (cmd == CMD_WRITE_CELL)};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cw_row_ff[0] <= row;
         cw_col_ff[0] <= col;
         cw_val_ff[0] <= wv;
         for (int i = 1; i < WD; i++) begin
            cw_row_ff[i] <= cw_row_ff[i-1];
            cw_col_ff[i] <= cw_col_ff[i-1];
            cw_val_ff[i] <= cw_val_ff[i-1];
         end
      end
   end

   logic [SEG_WIDTH-1:0] xs, ys;
   logic [FRAC_BITS:0]   wx, wy;
   logic signed [VALUE_WIDTH-1:0] res;

   tlbi_axis #(.MAX_POINTS(MAX_X_POINTS), .VALUE_WIDTH(VALUE_WIDTH),
      .FRAC_BITS(FRAC_BITS), .SEG_W(SEG_WIDTH)) u_x (
      .clock(clock), .enable(enable),
      .wr_en(acc && cmd == CMD_WRITE_X), .wr_index(row[$clog2(MAX_X_POINTS)-1:0]),
      .wr_value(VALUE_WIDTH'(wv)), .points(xn[$clog2(MAX_X_POINTS):0]),
      .coord(VALUE_WIDTH'(xq)), .seg(xs), .frac(wx)
   );

   tlbi_axis #(.MAX_POINTS(MAX_Y_POINTS), .VALUE_WIDTH(VALUE_WIDTH),
      .FRAC_BITS(FRAC_BITS), .SEG_W(SEG_WIDTH)) u_y (
      .clock(clock), .enable(enable),
      .wr_en(acc && cmd == CMD_WRITE_Y), .wr_index(col[$clog2(MAX_Y_POINTS)-1:0]),
      .wr_value(VALUE_WIDTH'(wv)), .points(yn[$clog2(MAX_Y_POINTS):0]),
      .coord(VALUE_WIDTH'(yq)), .seg(ys), .frac(wy)
   );

   tlbi_blend #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS),
      .VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS), .SEG_W(SEG_WIDTH)) u_blend (
      .clock(clock), .enable(enable),
      .wr_en(enable && cw_vld_ff[WD-1]),
      .wr_row(cw_row_ff[WD-1][$clog2(MAX_X_POINTS)-1:0]),
      .wr_col(cw_col_ff[WD-1][$clog2(MAX_Y_POINTS)-1:0]),
      .wr_value(VALUE_WIDTH'(cw_val_ff[WD-1])), .xs(xs), .ys(ys), .wx(wx), .wy(wy),
      .result(res)
   );

   // Segment and weight registers aligned with the blend output.
   logic [SEG_WIDTH-1:0] xs_d [4];
   logic [SEG_WIDTH-1:0] ys_d [4];
   logic [FRAC_BITS:0]   wx_d [4];
   logic [FRAC_BITS:0]   wy_d [4];
   always_ff @(posedge clock) begin
      if (enable) begin
         xs_d[0] <= xs; ys_d[0] <= ys; wx_d[0] <= wx; wy_d[0] <= wy;
         for (int i = 1; i < 4; i++) begin
            xs_d[i] <= xs_d[i-1]; ys_d[i] <= ys_d[i-1];
            wx_d[i] <= wx_d[i-1]; wy_d[i] <= wy_d[i-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {6'd0, wy_d[3][16:0], wx_d[3][16:0], ys_d[3], xs_d[3], 16'(res)};

   // A waiting response word stays put until it is taken.
   logic rsp_stall;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `TLB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "Response word dropped")
   `TLB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_tdata), "Data moved")
   `TLB_ASSERT_IMPL(a_idle_ready, clock, reset, !rsp_tvalid, req_tready, "Ready low while idle")
   `TLB_ASSERT_NEXT(a_write_quiet, clock, reset, acc && cmd != CMD_QUERY, !vld_ff[0], "Write queued")
endmodule
